### rtl/core/icdf_pkg.sv
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and constants of the inverse-CDF sampler: payload structs,
// opcodes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package icdf_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned OP_W        = 2;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned PROB_W      = 17;
  localparam int unsigned DRAW_W      = 16;

  // draw times span, and segment rise times value step
  localparam int unsigned SPAN_PROD_W = DRAW_W + PROB_W;
  localparam int unsigned PROD_W      = PROB_W + VALUE_W;
  localparam int unsigned DIV_CNT_W   = $clog2(PROD_W);

  localparam int unsigned DRAW_MAX    = 65535;
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [VALUE_W-1:0] point_value;
    logic [PROB_W-1:0]  point_prob;
    logic [DRAW_W-1:0]  uniform_draw;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic               table_empty;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic tbl_clear;
    logic tbl_load;
    logic smp_start;
    logic level_fix;
    logic scan_step;
    logic div_start;
    logic fin_interp;
    logic out_load;
    logic out_empty;
  } cmd_t;

  typedef struct packed {
    logic tbl_empty;
    logic scan_hit;
    logic scan_flat;
    logic scan_end;
    logic div_done;
  } sts_t;

endpackage

### rtl/core/icdf_div.sv
// ----------------------------------------------------------------------------
// icdf_div
// Restoring unsigned divider, one quotient bit per cycle, for the segment
// interpolation.
// ----------------------------------------------------------------------------
module icdf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [icdf_pkg::PROD_W-1:0]      dividend_i,
  input  logic [icdf_pkg::PROB_W-1:0]      divisor_i,
  output logic                             done_o,
  output logic [icdf_pkg::PROD_W-1:0]      quotient_o
);
  import icdf_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [PROB_W-1:0]     rem_q, rem_d;
  logic [PROB_W-1:0]     dsr_q;
  logic [PROD_W-1:0]     quo_q;
  logic [PROB_W:0]       trial;
  logic                  ge;

  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    ge    = trial >= {1'b0, dsr_q};
    if (ge) begin
      rem_d = PROB_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(PROD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[PROD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/icdf_dp.sv
// ----------------------------------------------------------------------------
// icdf_dp
// Datapath: point table memory, span tracking, level scaling, table scan,
// segment multiply and divide, saturation and the result register.
// ----------------------------------------------------------------------------
module icdf_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icdf_pkg::cmd_t       cmd_i,
  input  icdf_pkg::in_t        in_data_i,
  output icdf_pkg::sts_t       sts_o,
  output icdf_pkg::out_t       out_data_o
);
  import icdf_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PROB_W-1:0]  prob;
  } entry_t;

  entry_t               mem_q [TABLE_DEPTH];
  logic [CNT_W-1:0]     count_q;
  logic [PROB_W-1:0]    floor_q, ceil_q;
  logic [SPAN_PROD_W-1:0] x_q;
  logic [PROB_W-1:0]    level_q;
  logic [CNT_W-1:0]     iss_q;
  logic [IDX_W-1:0]     chk_q;
  logic                 rvalid_q;
  entry_t               rdata_q, prev_q;
  logic [PROB_W-1:0]    p1_q, p2_q;
  logic [VALUE_W-1:0]   v1_q, v2_q;
  logic [VALUE_W-1:0]   fin_q;
  logic                 neg_q;
  out_t                 out_q;

  logic [PROB_W-1:0]    span;
  logic [PROB_W-1:0]    lvl_base;
  logic [PROB_W:0]      lvl_rem;
  logic [1:0]           lvl_corr;
  logic [PROB_W-1:0]    lvl_d;

  logic                 hit, first, flat, last;
  logic [PROB_W-1:0]    seg_p1;
  logic [VALUE_W-1:0]   seg_v1;
  logic [VALUE_W:0]     mean_sum;

  logic [PROB_W-1:0]    num_mag, dp_mag;
  logic [VALUE_W-1:0]   dv_mag;
  logic                 neg_d;
  logic [PROD_W-1:0]    prod;
  logic                 div_done;
  logic [PROD_W-1:0]    quo;
  logic [PROD_W:0]      pos_sum;
  logic [VALUE_W-1:0]   interp;

  // level = floor + draw * span / 65535, reciprocal with remainder fix-up
  always_comb begin
    span     = ceil_q - floor_q;
    lvl_base = x_q[SPAN_PROD_W-1:DRAW_W];
    lvl_rem  = (PROB_W + 1)'(x_q[DRAW_W-1:0]) + (PROB_W + 1)'(lvl_base);
    if (lvl_rem >= (PROB_W + 1)'(3 * DRAW_MAX)) begin
      lvl_corr = 2'd3;
    end else if (lvl_rem >= (PROB_W + 1)'(2 * DRAW_MAX)) begin
      lvl_corr = 2'd2;
    end else if (lvl_rem >= (PROB_W + 1)'(DRAW_MAX)) begin
      lvl_corr = 2'd1;
    end else begin
      lvl_corr = 2'd0;
    end
    lvl_d = floor_q + lvl_base + PROB_W'(lvl_corr);
  end

  // scan compare on the registered read
  always_comb begin
    hit      = rvalid_q && (level_q <= rdata_q.prob);
    first    = chk_q == '0;
    seg_p1   = first ? '0 : prev_q.prob;
    seg_v1   = first ? '0 : prev_q.value;
    flat     = seg_p1 == rdata_q.prob;
    last     = rvalid_q && !hit && (CNT_W'(chk_q) == count_q - CNT_W'(1));
    mean_sum = (VALUE_W + 1)'(seg_v1) + (VALUE_W + 1)'(rdata_q.value);
  end

  // segment magnitudes and sign
  always_comb begin
    num_mag = (level_q >= p1_q) ? level_q - p1_q : p1_q - level_q;
    dp_mag  = (p2_q >= p1_q) ? p2_q - p1_q : p1_q - p2_q;
    dv_mag  = (v2_q >= v1_q) ? v2_q - v1_q : v1_q - v2_q;
    neg_d   = (level_q < p1_q) ^ (v2_q < v1_q) ^ (p2_q < p1_q);
    prod    = PROD_W'(num_mag) * PROD_W'(dv_mag);
  end

  icdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod),
    .divisor_i  (dp_mag),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // add the signed step to v1 and saturate
  always_comb begin
    pos_sum = (PROD_W + 1)'(v1_q) + (PROD_W + 1)'(quo);
    if (neg_q) begin
      if (quo > PROD_W'(v1_q)) begin
        interp = '0;
      end else begin
        interp = v1_q - quo[VALUE_W-1:0];
      end
    end else if (pos_sum > (PROD_W + 1)'({VALUE_W{1'b1}})) begin
      interp = '1;
    end else begin
      interp = pos_sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      floor_q  <= '0;
      ceil_q   <= PROB_ONE;
      rvalid_q <= 1'b0;
      iss_q    <= '0;
      chk_q    <= '0;
    end else begin
      if (cmd_i.tbl_clear) begin
        count_q <= '0;
        floor_q <= '0;
        ceil_q  <= PROB_ONE;
      end else if (cmd_i.tbl_load && (count_q < CNT_W'(TABLE_DEPTH))) begin
        count_q <= count_q + 1'b1;
        if (in_data_i.point_prob < floor_q) begin
          floor_q <= in_data_i.point_prob;
        end
        if (in_data_i.point_prob > ceil_q) begin
          ceil_q <= in_data_i.point_prob;
        end
      end
      if (cmd_i.smp_start) begin
        iss_q    <= '0;
        chk_q    <= '0;
        rvalid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rvalid_q <= iss_q < count_q;
        if (iss_q < count_q) begin
          iss_q <= iss_q + 1'b1;
        end
        if (rvalid_q && !hit) begin
          chk_q <= chk_q + 1'b1;
        end
      end else begin
        rvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_load && (count_q < CNT_W'(TABLE_DEPTH))) begin
      mem_q[count_q[IDX_W-1:0]] <= '{value: in_data_i.point_value,
                                     prob:  in_data_i.point_prob};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[iss_q[IDX_W-1:0]];
    if (cmd_i.smp_start) begin
      x_q <= SPAN_PROD_W'(in_data_i.uniform_draw) * SPAN_PROD_W'(span);
    end
    if (cmd_i.level_fix) begin
      level_q <= lvl_d;
    end
    if (cmd_i.scan_step && rvalid_q) begin
      if (hit) begin
        p1_q  <= seg_p1;
        v1_q  <= seg_v1;
        p2_q  <= rdata_q.prob;
        v2_q  <= rdata_q.value;
        fin_q <= mean_sum[VALUE_W:1];
      end else begin
        prev_q <= rdata_q;
        fin_q  <= rdata_q.value;
      end
    end
    if (cmd_i.div_start) begin
      neg_q <= neg_d;
    end
    if (cmd_i.fin_interp) begin
      fin_q <= interp;
    end
    if (cmd_i.out_load) begin
      out_q.sample_value <= cmd_i.out_empty ? '0 : fin_q;
      out_q.table_empty  <= cmd_i.out_empty;
    end
  end

  assign sts_o.tbl_empty = count_q == '0;
  assign sts_o.scan_hit  = hit;
  assign sts_o.scan_flat = flat;
  assign sts_o.scan_end  = last;
  assign sts_o.div_done  = div_done;
  assign out_data_o      = out_q;

endmodule

### rtl/core/icdf_ctrl.sv
// ----------------------------------------------------------------------------
// icdf_ctrl
// Controller: accepts items, sequences level, scan, multiply and divide, and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module icdf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [icdf_pkg::OP_W-1:0]     in_op_i,
  input  logic                          out_ready_i,
  input  icdf_pkg::sts_t                sts_i,
  output icdf_pkg::cmd_t                cmd_o,
  output logic                          in_ready_o,
  output logic                          out_valid_o
);
  import icdf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_e'(in_op_i))
            OP_CLEAR: cmd_o.tbl_clear = 1'b1;
            OP_LOAD:  cmd_o.tbl_load  = 1'b1;
            OP_SAMPLE: begin
              if (sts_i.tbl_empty) begin
                state_d = ST_EMPTY;
              end else begin
                cmd_o.smp_start = 1'b1;
                state_d         = ST_LEVEL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LEVEL: begin
        cmd_o.level_fix = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = sts_i.scan_flat ? ST_DONE : ST_MUL;
        end else if (sts_i.scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_MUL: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.fin_interp = 1'b1;
          state_d          = ST_DONE;
        end
      end
      ST_DONE, ST_EMPTY: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_empty = state_q == ST_EMPTY;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/inverse_cdf_sampler_unit.sv
// ----------------------------------------------------------------------------
// inverse_cdf_sampler_unit
// Inverse-transform sampler over a piecewise-linear CDF table of up to 64
// points.
// ----------------------------------------------------------------------------
// Clear and load items are taken in the idle state and give no result. A
// sample item first scales the draw into the probability span (the product
// is registered on acceptance, the level in the LEVEL state), then the scan
// reads one table entry per cycle through the single read port of the point
// memory up to the first point at or above the drawn level (or to the last
// point), then a multiply state and the restoring divider finish the
// interpolation. Flat segments and levels past the last point skip the
// divider. A sample of an empty table returns zero with table_empty set.
// The result sits in an output register, so the next item is taken as soon
// as the result is registered, even while it waits.
module inverse_cdf_sampler_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  icdf_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output icdf_pkg::out_t  out_data_o
);
  import icdf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  icdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.opcode),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  icdf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/core/icdf_checker.sv
// ----------------------------------------------------------------------------
// icdf_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module icdf_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_o,
  input  icdf_pkg::in_t   in_data_i,
  input  logic            out_valid_o,
  input  logic            out_ready_i,
  input  icdf_pkg::out_t  out_data_o
);
  import icdf_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a sample transfer makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode == OP_SAMPLE) |=> !in_ready_o)
    else $error("ready after sample transfer");

  // clear, load and unused codes leave the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode != OP_SAMPLE) |=> in_ready_o)
    else $error("busy after table transfer");

  // empty table result carries value zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_empty |-> out_data_o.sample_value == '0)
    else $error("empty result with nonzero value");

endmodule

bind inverse_cdf_sampler_unit icdf_checker u_icdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for inverse_cdf_sampler_unit. A short table of directed
// items covers the empty table, flat and falling segments, levels past the
// last point and the probability and value extremes. Random clear/load/sample
// sequences with noise follow. Each sample result is checked against its typed
// directed result or a table predictor, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import icdf_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t result;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // expectation typed into the directed table for the item now on the bus
  bit   typed_valid = 1'b0;
  out_t typed_result = '0;

  // predictor state
  logic [VALUE_W-1:0] cdf_vals [TABLE_DEPTH];
  logic [PROB_W-1:0]  cdf_probs [TABLE_DEPTH];
  int unsigned        cdf_count = 0;
  logic [PROB_W-1:0]  span_lo = '0;
  logic [PROB_W-1:0]  span_hi = PROB_ONE;

  out_t        pending_samples [$];
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;
  int unsigned gen_count = 0;
  int unsigned stim_count = 0;
  row_t        directed_rows [$];

  always #2 clk_i = ~clk_i;

  inverse_cdf_sampler_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  function automatic logic [VALUE_W-1:0] interp_segment(longint lvl, longint p1, longint v1,
                                                        longint p2, longint v2);
    longint q;
    longint r;
    if (p1 == p2) begin
      return VALUE_W'((v1 + v2) / 2);
    end
    q = ((lvl - p1) * (v2 - v1)) / (p2 - p1);
    r = v1 + q;
    if (r < 0) begin
      return '0;
    end
    if (r > longint'(32'hFFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end
    return VALUE_W'(r);
  endfunction

  function automatic void apply_to_table(input in_t it, output bit has_result,
                                         output out_t res);
    longint lvl;
    bit     found;
    has_result = 1'b0;
    res = '0;
    case (it.opcode)
      OP_CLEAR: begin
        cdf_count = 0;
        span_lo = '0;
        span_hi = PROB_ONE;
      end
      OP_LOAD: begin
        if (cdf_count < TABLE_DEPTH) begin
          cdf_vals[cdf_count] = it.point_value;
          cdf_probs[cdf_count] = it.point_prob;
          if (it.point_prob < span_lo) span_lo = it.point_prob;
          if (it.point_prob > span_hi) span_hi = it.point_prob;
          cdf_count++;
        end
      end
      OP_SAMPLE: begin
        has_result = 1'b1;
        if (cdf_count == 0) begin
          res.table_empty = 1'b1;
        end else begin
          lvl = longint'(span_lo) + (longint'(it.uniform_draw) *
                (longint'(span_hi) - longint'(span_lo))) / longint'(DRAW_MAX);
          res.sample_value = cdf_vals[cdf_count-1];
          found = 1'b0;
          for (int i = 0; i < cdf_count; i++) begin
            if (!found && lvl <= longint'(cdf_probs[i])) begin
              found = 1'b1;
              if (i == 0) begin
                res.sample_value = interp_segment(lvl, 0, 0, longint'(cdf_probs[0]),
                                                  longint'(cdf_vals[0]));
              end else begin
                res.sample_value = interp_segment(lvl, longint'(cdf_probs[i-1]),
                                                  longint'(cdf_vals[i-1]),
                                                  longint'(cdf_probs[i]),
                                                  longint'(cdf_vals[i]));
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_t make_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                                    logic [PROB_W-1:0] prob, logic [DRAW_W-1:0] draw);
    in_t it;
    it.opcode = op;
    it.point_value = val;
    it.point_prob = prob;
    it.uniform_draw = draw;
    return it;
  endfunction

  function automatic int idle_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic add_row(in_t it, bit fixed, logic [VALUE_W-1:0] val, logic empty);
    row_t row;
    row.item = it;
    row.fixed = fixed;
    row.result.sample_value = val;
    row.result.table_empty = empty;
    directed_rows.push_back(row);
  endtask

  task automatic drive_item(input in_t it, input bit fixed, input out_t fixed_res);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    typed_valid <= fixed;
    typed_result <= fixed_res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random(input in_t it);
    bit ignored;
    ignored = (it.opcode == OP_UNUSED) || (it.opcode == OP_LOAD && gen_count >= TABLE_DEPTH);
    if (it.opcode == OP_CLEAR) gen_count = 0;
    else if (it.opcode == OP_LOAD && gen_count < TABLE_DEPTH) gen_count++;
    if (!ignored) stim_count++;
    drive_item(it, 1'b0, '0);
  endtask

  function automatic logic [DRAW_W-1:0] pick_draw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return DRAW_W'($urandom);
  endfunction

  task automatic run_table_sequence();
    int unsigned n;
    int unsigned cur;
    int unsigned r;
    bit top;
    bit rising;
    logic [VALUE_W-1:0] val;
    send_random(make_item(OP_CLEAR, $urandom, PROB_W'($urandom), DRAW_W'($urandom)));
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(1, 8);
    else if (r < 95) n = $urandom_range(9, 40);
    else n = TABLE_DEPTH;
    top = $urandom_range(0, 3) != 0;
    rising = $urandom_range(0, 1);
    cur = 0;
    val = $urandom_range(0, 1000);
    for (int k = 0; k < n; k++) begin
      cur = cur + $urandom_range(0, 131072 / n);
      if (cur > 65536 || (top && k == n - 1)) cur = 65536;
      val = rising ? val + $urandom_range(0, 1 << 24) : $urandom;
      send_random(make_item(OP_LOAD, val, PROB_W'(cur), DRAW_W'($urandom)));
    end
    if (n == TABLE_DEPTH) begin
      repeat ($urandom_range(1, 3)) begin
        send_random(make_item(OP_LOAD, $urandom, PROB_W'($urandom_range(0, 131071)),
                              DRAW_W'($urandom)));
      end
    end
    repeat ($urandom_range(2, 10)) begin
      send_random(make_item(OP_SAMPLE, $urandom, PROB_W'($urandom), pick_draw()));
    end
  endtask

  always @(posedge clk_i) begin : monitor
    bit   moved;
    bit   has_result;
    out_t res;
    out_t want;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (pending_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result: value %h empty %b", out_data_o.sample_value,
                     out_data_o.table_empty);
          end
        end else begin
          want = pending_samples.pop_front();
          if (out_data_o.sample_value !== want.sample_value ||
              out_data_o.table_empty !== want.table_empty) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch: expected value %h empty %b, got value %h empty %b",
                       want.sample_value, want.table_empty, out_data_o.sample_value,
                       out_data_o.table_empty);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        apply_to_table(in_data_i, has_result, res);
        if (has_result) pending_samples.push_back(typed_valid ? typed_result : res);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned run;
    int unsigned gap;
    int unsigned r;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 80);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h1234), 1'b1, '0, 1'b1);
    add_row(make_item(OP_UNUSED, '1, '1, '1), 1'b0, '0, 1'b0);
    add_row(make_item(OP_CLEAR, '1, '1, '1), 1'b0, '0, 1'b0);
    add_row(make_item(OP_LOAD, 32'hFFFF_FFFF, PROB_ONE, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'hFFFF), 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h0000), 1'b1, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h8000), 1'b0, '0, 1'b0);
    add_row(make_item(OP_CLEAR, '0, '0, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '1, '1, 16'hFFFF), 1'b1, '0, 1'b1);
    add_row(make_item(OP_LOAD, 32'd100, '0, '1), 1'b0, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h0000), 1'b1, 32'd50, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h0001), 1'b1, 32'd100, 1'b0);
    add_row(make_item(OP_LOAD, 32'hFFFF_FFFF, 17'h1FFFF, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'hFFFF), 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h5555), 1'b0, '0, 1'b0);
    add_row(make_item(OP_CLEAR, '0, '0, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_LOAD, 32'd1000, 17'd32768, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_LOAD, 32'd10, 17'd49152, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_LOAD, 32'h5555_AAAA, 17'h0AAAA, '0), 1'b0, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'hAAAA), 1'b0, '0, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'hFFFF), 1'b1, 32'h5555_AAAA, 1'b0);
    add_row(make_item(OP_SAMPLE, '0, '0, 16'h4000), 1'b0, '0, 1'b0);
    add_row(make_item(OP_CLEAR, '0, '0, '0), 1'b0, '0, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);
    end

    while (stim_count < RANDOM_ITEMS) begin
      calm = $urandom_range(0, 9) == 0;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        run_table_sequence();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) begin
          send_random(make_item(OP_W'($urandom_range(0, 3)), $urandom,
                                PROB_W'($urandom_range(0, 131071)), DRAW_W'($urandom)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_random(make_item(OP_LOAD, $urandom, PROB_W'($urandom_range(0, 131071)),
                                DRAW_W'($urandom)));
        end
        repeat ($urandom_range(1, 3)) begin
          send_random(make_item(OP_SAMPLE, $urandom, PROB_W'($urandom), pick_draw()));
        end
      end
    end
    in_valid_i <= 1'b0;
    typed_valid <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/icdf_pkg.sv
rtl/core/icdf_div.sv
rtl/core/icdf_dp.sv
rtl/core/icdf_ctrl.sv
rtl/core/inverse_cdf_sampler_unit.sv
rtl/core/icdf_checker.sv
bench/tb.sv
